/* design/ftpp_pkg.sv */
// Shared types and constants of the file transfer packet parser.
package ftpp_pkg;

  localparam int unsigned CfgW         = 10;
  localparam int unsigned DataMax      = 512;
  localparam logic [CfgW-1:0] MaxDataRst = 10'd512;
  localparam int unsigned FifoDepthDef = 4;

  // opcodes
  localparam logic [3:0] OP_RRQ   = 4'd1;
  localparam logic [3:0] OP_WRQ   = 4'd2;
  localparam logic [3:0] OP_DATA  = 4'd3;
  localparam logic [3:0] OP_ACK   = 4'd4;
  localparam logic [3:0] OP_ERROR = 4'd5;
  localparam logic [3:0] OP_DIRQ  = 4'd6;
  localparam logic [3:0] OP_LOGRQ = 4'd7;
  localparam logic [3:0] OP_DELRQ = 4'd8;
  localparam logic [3:0] OP_BCAST = 4'd9;
  localparam logic [3:0] OP_DISC  = 4'd10;

  // field kinds
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_OPCODE  = 3'd1;
  localparam logic [2:0] KIND_BLOCK   = 3'd2;
  localparam logic [2:0] KIND_SIZE    = 3'd3;
  localparam logic [2:0] KIND_ERRCODE = 3'd4;
  localparam logic [2:0] KIND_TEXT    = 3'd5;
  localparam logic [2:0] KIND_DATA    = 3'd6;
  localparam logic [2:0] KIND_FLAG    = 3'd7;

  // parse status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_OP   = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       is_zero;
  } item_t;

  typedef struct packed {
    logic [3:0]  message_type;
    logic [2:0]  field_kind;
    logic [15:0] field_value;
    logic        field_valid;
    logic        message_done;
    logic [15:0] message_length;
    logic [1:0]  parse_status;
  } res_t;

endpackage

/* design/ftpp_front.sv */
// Input stage: registers each byte and tags terminator bytes.
module ftpp_front import ftpp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       push_o,
  output item_t      push_item_o,
  input  logic       q_ready_i
);

  logic  vld_q, vld_d;
  item_t item_q;

  assign in_ready_o  = !vld_q || q_ready_i;
  assign push_o      = vld_q && q_ready_i;
  assign push_item_o = item_q;
  assign vld_d       = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.data    <= in_byte_i;
      item_q.is_zero <= (in_byte_i == 8'h00);
    end
  end

endmodule

/* design/ftpp_fifo.sv */
// Short queue of classified bytes between the input stage and the parser.
module ftpp_fifo import ftpp_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  ready_o,
  output logic  valid_o,
  output item_t head_o,
  input  logic  pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             wr, rd;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign wr      = push_i && ready_o;
  assign rd      = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* design/ftpp_parse.sv */
// Packet field parser with the size limit register and the result register.
module ftpp_parse import ftpp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  input  item_t           in_item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  output res_t            out_res_o,
  input  logic            out_ready_i
);

  typedef enum logic [3:0] {
    STEP_OP = 4'b0001,
    STEP_F1 = 4'b0010,
    STEP_F2 = 4'b0100,
    STEP_F3 = 4'b1000
  } step_e;

  step_e           step_q, step_d;
  logic [7:0]      hi_q, hi_d;
  logic            hflag_q, hflag_d;
  logic [3:0]      op_q, op_d;
  logic [9:0]      size_q, size_d;
  logic [9:0]      count_q, count_d;
  logic [15:0]     total_q, total_d, total_inc;
  logic [CfgW-1:0] max_q;
  logic            ovld_q;
  res_t            ores_q, res;

  logic [7:0]  b;
  logic [15:0] word, lim, max16;
  logic        use16, clear, done, bad, fire, in_ready;
  logic [9:0]  count_inc;

  assign in_ready    = !ovld_q || out_ready_i;
  assign fire        = in_valid_i && in_ready;
  assign pop_o       = fire;
  assign out_valid_o = ovld_q;
  assign out_res_o   = ores_q;

  assign b         = in_item_i.data;
  assign word      = {hi_q, b};
  assign max16     = {6'b0, max_q};
  assign lim       = (max16 < 16'(DataMax)) ? max16 : 16'(DataMax);
  assign total_inc = (total_q != 16'hffff) ? total_q + 16'd1 : total_q;
  assign count_inc = count_q + 10'd1;

  always_comb begin
    res     = '0;
    step_d  = step_q;
    hi_d    = hi_q;
    hflag_d = hflag_q;
    op_d    = op_q;
    size_d  = size_q;
    count_d = count_q;
    total_d = total_inc;
    use16   = 1'b0;
    clear   = 1'b0;
    done    = 1'b0;
    bad     = 1'b0;

    unique case (step_q)
      STEP_OP: begin
        use16 = 1'b1;
        if (hflag_q) begin
          if (word >= 16'd1 && word <= 16'd10) begin
            op_d             = word[3:0];
            res.message_type = word[3:0];
            res.field_kind   = KIND_OPCODE;
            res.field_value  = word;
            res.field_valid  = 1'b1;
            if (word[3:0] == OP_DIRQ || word[3:0] == OP_DISC) begin
              done = 1'b1;
            end else begin
              step_d = STEP_F1;
            end
          end else begin
            res.field_value  = word;
            res.parse_status = ST_BAD_OP;
            clear            = 1'b1;
          end
        end
      end
      STEP_F1: begin
        res.message_type = op_q;
        unique case (op_q) inside
          OP_RRQ, OP_WRQ, OP_LOGRQ, OP_DELRQ: begin
            if (!in_item_i.is_zero) begin
              res.field_kind  = KIND_TEXT;
              res.field_value = {8'h00, b};
              res.field_valid = 1'b1;
            end else begin
              done = 1'b1;
            end
          end
          OP_DATA: begin
            use16 = 1'b1;
            if (hflag_q) begin
              res.field_kind  = KIND_SIZE;
              res.field_value = word;
              if (word > lim) begin
                res.parse_status = ST_OVERSIZE;
                clear            = 1'b1;
              end else begin
                res.field_valid = 1'b1;
                size_d          = word[9:0];
                count_d         = '0;
                step_d          = STEP_F2;
              end
            end
          end
          OP_ACK: begin
            use16 = 1'b1;
            if (hflag_q) begin
              res.field_kind  = KIND_BLOCK;
              res.field_value = word;
              res.field_valid = 1'b1;
              done            = 1'b1;
            end
          end
          OP_ERROR: begin
            use16 = 1'b1;
            if (hflag_q) begin
              res.field_kind  = KIND_ERRCODE;
              res.field_value = word;
              res.field_valid = 1'b1;
              step_d          = STEP_F2;
            end
          end
          OP_BCAST: begin
            res.field_kind  = KIND_FLAG;
            res.field_value = {8'h00, b};
            res.field_valid = 1'b1;
            step_d          = STEP_F2;
          end
          default: bad = 1'b1;
        endcase
      end
      STEP_F2: begin
        res.message_type = op_q;
        unique case (op_q) inside
          OP_DATA: begin
            use16 = 1'b1;
            if (hflag_q) begin
              res.field_kind  = KIND_BLOCK;
              res.field_value = word;
              res.field_valid = 1'b1;
              if (size_q == '0) begin
                done = 1'b1;
              end else begin
                step_d = STEP_F3;
              end
            end
          end
          OP_ERROR, OP_BCAST: begin
            if (!in_item_i.is_zero) begin
              res.field_kind  = KIND_TEXT;
              res.field_value = {8'h00, b};
              res.field_valid = 1'b1;
            end else begin
              done = 1'b1;
            end
          end
          default: bad = 1'b1;
        endcase
      end
      STEP_F3: begin
        res.message_type = op_q;
        if (op_q == OP_DATA) begin
          res.field_kind  = KIND_DATA;
          res.field_value = {8'h00, b};
          res.field_valid = 1'b1;
          count_d         = count_inc;
          if (count_inc >= size_q) begin
            done = 1'b1;
          end
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase

    // first byte of a 16-bit field is held, the second releases it
    if (use16) begin
      hi_d    = hflag_q ? 8'h00 : b;
      hflag_d = !hflag_q;
    end

    if (bad) begin
      res   = '0;
      clear = 1'b1;
    end else if (done) begin
      res.message_done   = 1'b1;
      res.message_length = total_inc;
      clear              = 1'b1;
    end

    if (clear) begin
      step_d  = STEP_OP;
      hi_d    = '0;
      hflag_d = 1'b0;
      op_d    = '0;
      size_d  = '0;
      count_d = '0;
      total_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_OP;
      hi_q    <= '0;
      hflag_q <= 1'b0;
      op_q    <= '0;
      size_q  <= '0;
      count_q <= '0;
      total_q <= '0;
      max_q   <= MaxDataRst;
      ovld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (fire) begin
        step_q  <= step_d;
        hi_q    <= hi_d;
        hflag_q <= hflag_d;
        op_q    <= op_d;
        size_q  <= size_d;
        count_q <= count_d;
        total_q <= total_d;
      end
      if (in_ready) begin
        ovld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ores_q <= res;
    end
  end

endmodule

/* design/file_transfer_packet_parser.sv */
// Top level of the file transfer packet parser.
//
//   channel  | dir | transaction                  | payload
//   s_axis   | in  | one raw packet byte          | tdata[7:0] byte
//   m_axis   | out | one parse result per byte    | tdata/tuser/tlast, see ports
//   cfg      | in  | write of max data size       | cfg_wdata_i[9:0]
//
// One byte is taken per cycle while the output is not stalled, and gives one
// result; throughput is set by the field update in the parser. The path from
// input to output runs through the input register, queue and result register.
// Reset clears all parse state and sets the size limit to 512; no clearing pass.
// A stalled output fills the result register, then the queue, then the input
// register before s_axis_tready drops.
module file_transfer_packet_parser import ftpp_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [7:0] in_byte
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // [3:0] message_type, [19:4] field_value, [20] field_valid,
  // [36:21] message_length, [38:37] parse_status, [39] zero
  output logic [39:0]     m_axis_tdata,
  output logic [2:0]      m_axis_tuser,   // [2:0] field_kind
  output logic            m_axis_tlast,   // message_done
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  logic  push, q_ready, q_valid, pop;
  item_t push_item, head;
  res_t  res;

  ftpp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .push_o      (push),
    .push_item_o (push_item),
    .q_ready_i   (q_ready)
  );

  ftpp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  ftpp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (q_valid),
    .in_item_i   (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, res.parse_status, res.message_length, res.field_valid,
                         res.field_value, res.message_type};
  assign m_axis_tuser = res.field_kind;
  assign m_axis_tlast = res.message_done;

  // a finished message always reports a nonzero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[36:21] != 16'd0)
    else $error("message done with zero length");

  // an error result never carries a valid field or a message end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[38:37] != ST_OK |-> !m_axis_tdata[20] && !m_axis_tlast)
    else $error("error result marked valid or done");

  // an opcode result names the same opcode as message type
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_OPCODE
      |-> m_axis_tdata[3:0] == m_axis_tdata[7:4] && m_axis_tdata[3:0] != 4'd0)
    else $error("opcode result disagrees with message type");

  // length is reported only with the end of a message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[36:21] == 16'd0)
    else $error("length reported outside message end");

endmodule
